// ----- hdl/mck_pkg.sv -----
// Shared types and the character code table for the Morse character keyer.
package mck_pkg;

    localparam int unsigned CharW   = 8;
    localparam int unsigned PatW    = 7;
    localparam int unsigned LenW    = 3;
    localparam int unsigned DurW    = 2;

    localparam logic [DurW-1:0] DurShort = 2'd1;
    localparam logic [DurW-1:0] DurLong  = 2'd3;

    typedef struct packed {
        logic            known;
        logic            space;
        logic [LenW-1:0] len;
        logic [PatW-1:0] pat;
    } t_code;

    typedef struct packed {
        logic            go;
        logic            space;
        logic [LenW-1:0] len;
        logic [PatW-1:0] pat;
    } t_start;

    typedef struct packed {
        logic busy;
    } t_status;

    // Symbols are given first-symbol-leftmost in the low bits and left-aligned here.
    function automatic t_code mk(input logic [LenW-1:0] len, input logic [PatW-1:0] bits);
        t_code c;
        c.known = 1'b1;
        c.space = 1'b0;
        c.len   = len;
        c.pat   = PatW'(bits << (3'd7 - len));
        return c;
    endfunction

    function automatic t_code lookup(input logic [CharW-1:0] ch);
        t_code c;
        c = '0;
        case (ch)
            8'h41: c = mk(3'd2, 7'b01);
            8'h42: c = mk(3'd4, 7'b1000);
            8'h43: c = mk(3'd4, 7'b1010);
            8'h44: c = mk(3'd3, 7'b100);
            8'h45: c = mk(3'd1, 7'b0);
            8'h46: c = mk(3'd4, 7'b0010);
            8'h47: c = mk(3'd3, 7'b110);
            8'h48: c = mk(3'd4, 7'b0000);
            8'h49: c = mk(3'd2, 7'b00);
            8'h4A: c = mk(3'd4, 7'b0111);
            8'h4B: c = mk(3'd3, 7'b101);
            8'h4C: c = mk(3'd4, 7'b0100);
            8'h4D: c = mk(3'd2, 7'b11);
            8'h4E: c = mk(3'd2, 7'b10);
            8'h4F: c = mk(3'd3, 7'b111);
            8'h50: c = mk(3'd4, 7'b0110);
            8'h51: c = mk(3'd4, 7'b1101);
            8'h52: c = mk(3'd3, 7'b010);
            8'h53: c = mk(3'd3, 7'b000);
            8'h54: c = mk(3'd1, 7'b1);
            8'h55: c = mk(3'd3, 7'b001);
            8'h56: c = mk(3'd4, 7'b0001);
            8'h57: c = mk(3'd3, 7'b011);
            8'h58: c = mk(3'd4, 7'b1001);
            8'h59: c = mk(3'd4, 7'b1011);
            8'h5A: c = mk(3'd4, 7'b1100);
            8'h30: c = mk(3'd5, 7'b11111);
            8'h31: c = mk(3'd5, 7'b01111);
            8'h32: c = mk(3'd5, 7'b00111);
            8'h33: c = mk(3'd5, 7'b00011);
            8'h34: c = mk(3'd5, 7'b00001);
            8'h35: c = mk(3'd5, 7'b00000);
            8'h36: c = mk(3'd5, 7'b10000);
            8'h37: c = mk(3'd5, 7'b11000);
            8'h38: c = mk(3'd5, 7'b11100);
            8'h39: c = mk(3'd5, 7'b11110);
            8'h2E: c = mk(3'd6, 7'b010101);
            8'h2C: c = mk(3'd6, 7'b110011);
            8'h3F: c = mk(3'd6, 7'b001100);
            8'h27: c = mk(3'd6, 7'b011110);
            8'h21: c = mk(3'd6, 7'b101011);
            8'h2F: c = mk(3'd5, 7'b10010);
            8'h28: c = mk(3'd5, 7'b10110);
            8'h29: c = mk(3'd6, 7'b101101);
            8'h26: c = mk(3'd5, 7'b01000);
            8'h3A: c = mk(3'd6, 7'b111000);
            8'h3B: c = mk(3'd6, 7'b101010);
            8'h3D: c = mk(3'd5, 7'b10001);
            8'h2B: c = mk(3'd5, 7'b01010);
            8'h2D: c = mk(3'd6, 7'b100001);
            8'h5F: c = mk(3'd6, 7'b001101);
            8'h22: c = mk(3'd6, 7'b010010);
            8'h24: c = mk(3'd7, 7'b0001001);
            8'h40: c = mk(3'd6, 7'b011010);
            8'h20: begin
                c.known = 1'b1;
                c.space = 1'b1;
                c.len   = 3'd1;
                c.pat   = '0;
            end
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/mck_seg_gen.sv -----
// Sequencer: shifts the symbol pattern out one segment per unstalled cycle to an output register.
module mck_seg_gen (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mck_pkg::t_start               i_start,
    output mck_pkg::t_status              o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_tone_on,
    output logic [mck_pkg::DurW-1:0]      o_duration_units,
    output logic                          o_last_segment
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SYM  = 4'b0010,
        S_SIL  = 4'b0100,
        S_GAP  = 4'b1000
    } t_state;

    t_state                       r_state, n_state;
    logic [mck_pkg::PatW-1:0]     r_pat, n_pat;
    logic [mck_pkg::LenW-1:0]     r_cnt, n_cnt;
    logic                         r_space, n_space;
    logic                         r_out_valid, n_out_valid;
    logic                         r_tone, n_tone;
    logic [mck_pkg::DurW-1:0]     r_dur, n_dur;
    logic                         r_last, n_last;
    logic                         w_load;

    assign w_load = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_pat       = r_pat;
        n_cnt       = r_cnt;
        n_space     = r_space;
        n_out_valid = r_out_valid && i_out_stall;
        n_tone      = r_tone;
        n_dur       = r_dur;
        n_last      = r_last;
        case (r_state)
            S_IDLE: begin
                if (i_start.go) begin
                    n_state = S_SYM;
                    n_pat   = i_start.pat;
                    n_cnt   = i_start.len;
                    n_space = i_start.space;
                end
            end
            S_SYM: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_tone      = !r_space;
                    n_dur       = (r_space || r_pat[mck_pkg::PatW-1]) ?
                                  mck_pkg::DurLong : mck_pkg::DurShort;
                    n_last      = 1'b0;
                    n_state     = S_SIL;
                end
            end
            S_SIL: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_tone      = 1'b0;
                    n_dur       = mck_pkg::DurShort;
                    n_last      = 1'b0;
                    n_pat       = {r_pat[mck_pkg::PatW-2:0], 1'b0};
                    n_cnt       = r_cnt - 3'd1;
                    n_state     = (r_cnt == 3'd1) ? S_GAP : S_SYM;
                end
            end
            S_GAP: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_tone      = 1'b0;
                    n_dur       = mck_pkg::DurLong;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_pat   <= n_pat;
        r_cnt   <= n_cnt;
        r_space <= n_space;
        r_tone  <= n_tone;
        r_dur   <= n_dur;
        r_last  <= n_last;
    end

    assign o_status.busy    = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_tone_on        = r_tone;
    assign o_duration_units = r_dur;
    assign o_last_segment   = r_last;

endmodule

// ----- hdl/morse_character_keyer_top.sv -----
// Top level of the Morse character keyer: code lookup, abort flag and segment sequencer.
//
//  Channel | Direction | Handshake             | Payload
//  input   | in        | i_in_valid/o_in_stall | i_char_code, i_end_of_string
//  output  | out       | o_out_valid/i_out_stall | o_tone_on, o_duration_units, o_last_segment
//
// Known characters go out as a symbol and a silence segment per symbol and a closing gap, one
// segment per unstalled cycle from the shared shifter; unknown or skipped ones emit none.
// Reset is synchronous and active low; it clears the abort flag and the sequencer.
// Output stalls hold the output register and delay the sequencer.
module morse_character_keyer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [mck_pkg::CharW-1:0]     i_char_code,
    input  logic                          i_end_of_string,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_tone_on,
    output logic [mck_pkg::DurW-1:0]      o_duration_units,
    output logic                          o_last_segment
);

    mck_pkg::t_code   w_code;
    mck_pkg::t_start  w_start;
    mck_pkg::t_status w_status;
    logic             w_accept;
    logic             r_aborted, n_aborted;

    assign w_code     = mck_pkg::lookup(i_char_code);
    assign o_in_stall = w_status.busy;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_start.go    = w_accept && !r_aborted && w_code.known;
    assign w_start.space = w_code.space;
    assign w_start.len   = w_code.len;
    assign w_start.pat   = w_code.pat;

    always_comb begin
        n_aborted = r_aborted;
        if (w_accept) begin
            if (i_end_of_string) begin
                n_aborted = 1'b0;
            end else if (!r_aborted && !w_code.known) begin
                n_aborted = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aborted <= 1'b0;
        end else begin
            r_aborted <= n_aborted;
        end
    end

    mck_seg_gen u_seg_gen (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (w_start),
        .o_status         (w_status),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_tone_on        (o_tone_on),
        .o_duration_units (o_duration_units),
        .o_last_segment   (o_last_segment)
    );

    a_last_is_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_segment) |-> (!o_tone_on && o_duration_units == mck_pkg::DurLong))
        else $error("closing segment is not a long silence");

    a_dur_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_duration_units == mck_pkg::DurShort ||
                         o_duration_units == mck_pkg::DurLong))
        else $error("illegal segment duration");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start.go |=> o_in_stall)
        else $error("sequencer did not start on a known character");

    a_abort_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (r_aborted || !w_code.known)) |=> !o_in_stall)
        else $error("skipped character started the sequencer");

endmodule
